[rtl/rds_af_code_pair_decoder_macros.svh]
// assertion helpers for the rds af code pair decoder
`ifndef RDS_AF_CODE_PAIR_DECODER_MACROS_SVH
`define RDS_AF_CODE_PAIR_DECODER_MACROS_SVH

// property checked on every clock edge outside reset
`define RDSAF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define RDSAF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rdsaf_pkg.sv]
`default_nettype none

package rdsaf_pkg;

   // result kinds
   localparam logic [2:0] KIND_PLAIN    = 3'd0;
   localparam logic [2:0] KIND_TUNING   = 3'd1;
   localparam logic [2:0] KIND_SAME_PRG = 3'd2;
   localparam logic [2:0] KIND_REGIONAL = 3'd3;
   localparam logic [2:0] KIND_COUNT    = 3'd4;

   // code ranges
   localparam logic [7:0] VHF_CODE_MIN   = 8'd1;
   localparam logic [7:0] VHF_CODE_MAX   = 8'd204;
   localparam logic [7:0] COUNT_CODE_MIN = 8'd224;
   localparam logic [7:0] COUNT_CODE_MAX = 8'd249;
   localparam logic [7:0] LFMF_CODE      = 8'd250;
   localparam logic [7:0] LF_CODE_MIN    = 8'd1;
   localparam logic [7:0] LF_CODE_MAX    = 8'd15;
   localparam logic [7:0] MF_CODE_MIN    = 8'd16;
   localparam logic [7:0] MF9_CODE_MAX   = 8'd135;
   localparam logic [7:0] MF10_CODE_MAX  = 8'd124;

   localparam logic [1:0] REGION_MF10 = 2'd2;
   localparam logic [1:0] REGION_RESET = 2'd1;

   // frequency = base + step * code, bases folded with the code offsets
   localparam logic [16:0] VHF_BASE  = 17'd87500;
   localparam logic [16:0] VHF_STEP  = 17'd100;
   localparam logic [16:0] MF10_BASE = 17'd370;   // 530 - 16*10
   localparam logic [16:0] MF10_STEP = 17'd10;
   localparam logic [16:0] LF9_BASE  = 17'd144;   // 153 - 1*9
   localparam logic [16:0] MF9_BASE  = 17'd387;   // 531 - 16*9
   localparam logic [16:0] LFMF9_STEP = 17'd9;

   localparam int MAX_RESULTS = 3;

   typedef enum logic [2:0] {
      FREQ_ZERO,
      FREQ_VHF,
      FREQ_MF10,
      FREQ_LF9,
      FREQ_MF9
   } freq_sel_type;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_VHF,
      CLS_COUNT,
      CLS_LFMF
   } class_type;

   typedef struct packed {
      freq_sel_type sel;
      logic [7:0]   code;
      logic [2:0]   kind;
      logic [4:0]   follow_count;
   } af_op_type;

   typedef struct packed {
      logic [1:0]                       cnt;
      af_op_type [MAX_RESULTS-1:0]      ops;
   } af_job_type;

   typedef struct packed {
      logic [7:0] code_first;
      logic [7:0] code_second;
   } req_type;

   typedef struct packed {
      logic [16:0] freq_khz;
      logic [2:0]  kind;
      logic [4:0]  follow_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

[rtl/rdsaf_front.sv]
`default_nettype none

module rdsaf_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire logic               full,
   input  wire rdsaf_pkg::req_type req_data,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_wr_data,
   output logic                    enq,
   output rdsaf_pkg::af_job_type   job
);
   import rdsaf_pkg::*;

   logic [7:0] tuning_code_ff, tuning_code_in;
   logic       first_pending_ff, first_pending_in;
   logic [1:0] itu_region_ff;
   logic       accept;
   logic [7:0] a, b;
   class_type  cls;

   assign accept = push & ~full;
   assign a = req_data.code_first;
   assign b = req_data.code_second;

   always_comb begin
      priority if (a >= VHF_CODE_MIN && a <= VHF_CODE_MAX) begin
         cls = CLS_VHF;
      end else if (a >= COUNT_CODE_MIN && a <= COUNT_CODE_MAX) begin
         cls = CLS_COUNT;
      end else if (a == LFMF_CODE) begin
         cls = CLS_LFMF;
      end else begin
         cls = CLS_NONE;
      end
   end

   // build the list of up to three entries this pair produces
   always_comb begin
      logic [1:0] n;
      logic       match;
      logic [7:0] other;
      n     = 2'd0;
      match = (a == tuning_code_ff) || (b == tuning_code_ff);
      other = (a == tuning_code_ff) ? b : a;
      job   = '0;
      tuning_code_in   = tuning_code_ff;
      first_pending_in = first_pending_ff;
      unique case (cls)
         CLS_VHF: begin
            if (first_pending_ff) begin
               job.ops[n] = '{FREQ_VHF, tuning_code_ff,
                              (match ? KIND_TUNING : KIND_PLAIN), 5'd0};
               n = n + 2'd1;
            end
            if (match) begin
               job.ops[n] = '{FREQ_VHF, other,
                              ((a < b) ? KIND_SAME_PRG : KIND_REGIONAL), 5'd0};
               n = n + 2'd1;
            end else begin
               job.ops[n] = '{FREQ_VHF, a, KIND_PLAIN, 5'd0};
               n = n + 2'd1;
               if (b >= VHF_CODE_MIN && b <= VHF_CODE_MAX) begin
                  job.ops[n] = '{FREQ_VHF, b, KIND_PLAIN, 5'd0};
                  n = n + 2'd1;
               end
            end
            first_pending_in = 1'b0;
         end
         CLS_COUNT: begin
            job.ops[n] = '{FREQ_ZERO, 8'd0, KIND_COUNT, 5'(a - COUNT_CODE_MIN)};
            n = n + 2'd1;
            if (a == COUNT_CODE_MIN + 8'd1) begin
               job.ops[n] = '{FREQ_VHF, b, KIND_PLAIN, 5'd0};
               n = n + 2'd1;
            end
            tuning_code_in   = b;
            first_pending_in = 1'b1;
         end
         CLS_LFMF: begin
            if (first_pending_ff) begin
               job.ops[n] = '{FREQ_VHF, tuning_code_ff, KIND_PLAIN, 5'd0};
               n = n + 2'd1;
            end
            if (itu_region_ff == REGION_MF10) begin
               if (b >= MF_CODE_MIN && b <= MF10_CODE_MAX) begin
                  job.ops[n] = '{FREQ_MF10, b, KIND_PLAIN, 5'd0};
                  n = n + 2'd1;
               end
            end else if (b >= LF_CODE_MIN && b <= LF_CODE_MAX) begin
               job.ops[n] = '{FREQ_LF9, b, KIND_PLAIN, 5'd0};
               n = n + 2'd1;
            end else if (b >= MF_CODE_MIN && b <= MF9_CODE_MAX) begin
               job.ops[n] = '{FREQ_MF9, b, KIND_PLAIN, 5'd0};
               n = n + 2'd1;
            end
            first_pending_in = 1'b0;
         end
         CLS_NONE: begin
            n = 2'd0;
         end
         default: begin
            n = 2'd0;
         end
      endcase
      job.cnt = n;
   end

   // pairs that yield nothing still update state but skip the queue
   assign enq = accept && (job.cnt != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_code_ff   <= 8'd0;
         first_pending_ff <= 1'b0;
         itu_region_ff    <= REGION_RESET;
      end else begin
         if (accept) begin
            tuning_code_ff   <= tuning_code_in;
            first_pending_ff <= first_pending_in;
         end
         if (csr_wr_en) begin
            itu_region_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/rdsaf_queue.sv]
`default_nettype none

module rdsaf_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire rdsaf_pkg::af_job_type    wr_data,
   input  wire logic                     rd_en,
   output rdsaf_pkg::af_job_type         rd_data,
   output rdsaf_pkg::queue_status_type   status
);
   import rdsaf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   af_job_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_wr, do_rd;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr   = wr_en & ~status.full;
   assign do_rd   = rd_en & ~status.empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/rdsaf_back.sv]
`default_nettype none

module rdsaf_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rdsaf_pkg::af_job_type    head,
   input  wire logic                     head_valid,
   output logic                          head_done,
   input  wire logic                     pop,
   output logic                          empty,
   output rdsaf_pkg::rsp_type            rsp_data
);
   import rdsaf_pkg::*;

   logic [1:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     rsp_ff, rsp_in;
   af_op_type   op;
   logic        load, is_last;
   logic [16:0] code_w;
   logic [16:0] freq;

   assign op      = head.ops[idx_ff];
   assign is_last = (idx_ff == head.cnt - 2'd1);
   assign load    = head_valid && (!out_valid_ff || pop);
   assign head_done = load && is_last;
   assign code_w  = 17'(op.code);

   always_comb begin
      unique case (op.sel)
         FREQ_ZERO: freq = 17'd0;
         FREQ_VHF:  freq = VHF_BASE + code_w * VHF_STEP;
         FREQ_MF10: freq = MF10_BASE + code_w * MF10_STEP;
         FREQ_LF9:  freq = LF9_BASE + code_w * LFMF9_STEP;
         FREQ_MF9:  freq = MF9_BASE + code_w * LFMF9_STEP;
         default:   freq = 17'd0;
      endcase
   end

   always_comb begin
      rsp_in.freq_khz     = freq;
      rsp_in.kind         = op.kind;
      rsp_in.follow_count = op.follow_count;
      rsp_in.last         = is_last;
      if (load) begin
         idx_in       = is_last ? 2'd0 : idx_ff + 2'd1;
         out_valid_in = 1'b1;
      end else begin
         idx_in       = idx_ff;
         out_valid_in = out_valid_ff & ~pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign empty    = ~out_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[rtl/rds_af_code_pair_decoder.sv]
`default_nettype none

// RDS alternative-frequency pair decoder. Each transfer on the request side
// carries one pair of AF codes; the block answers with zero to three result
// transfers, the final one of a pair flagged by last. A count code (224..249)
// yields a header of kind 4 and stores the tuning code, VHF pairs decode by
// method A or B against that tuning code, code 250 yields an LF/MF entry
// whose spacing follows the ITU region register (csr_wr_data, reset 1, write
// only while idle). Filler and unassigned codes yield nothing. A pair is
// taken whenever push is high and full is low; the result side sends one
// entry per cycle while the result register is free or popped, and the
// back-end sequencer walks the entries of each pair. The first result of a
// pair passes through a queue slot and then the result register on its way out.
module rds_af_code_pair_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request side
   input  wire logic               push,
   output logic                    full,
   input  wire rdsaf_pkg::req_type req_data,
   // result side
   output logic                    empty,
   input  wire logic               pop,
   output rdsaf_pkg::rsp_type      rsp_data,
   // region register
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_wr_data
);
   import rdsaf_pkg::*;

   // front to queue
   logic             enq;
   af_job_type       enq_job;
   // queue to back
   af_job_type       head_job;
   queue_status_type q_status;
   logic             head_done;

   assign full = q_status.full;

   // front: classify the pair, update tuning state, list the entries
   rdsaf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (q_status.full),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .enq         (enq),
      .job         (enq_job)
   );

   // short job queue decouples intake from result output
   rdsaf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (enq),
      .wr_data (enq_job),
      .rd_en   (head_done),
      .rd_data (head_job),
      .status  (q_status)
   );

   // back: one entry per cycle into the result register while it is free or popped
   rdsaf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_job),
      .head_valid (~q_status.empty),
      .head_done  (head_done),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/rdsaf_checker.sv]
`default_nettype none

`include "rds_af_code_pair_decoder_macros.svh"

module rdsaf_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               empty,
   input wire logic               pop,
   input wire rdsaf_pkg::rsp_type rsp_data
);
   import rdsaf_pkg::*;

   `RDSAF_ASSERT_ALWAYS(a_empty_after_reset, clock,
      reset |=> empty, "result side not empty after reset")

   `RDSAF_ASSERT(a_header_zero_freq, clock, reset,
      !empty && rsp_data.kind == KIND_COUNT |-> rsp_data.freq_khz == 17'd0,
      "count header with nonzero frequency")

   `RDSAF_ASSERT(a_follow_only_header, clock, reset,
      !empty && rsp_data.kind != KIND_COUNT |-> rsp_data.follow_count == 5'd0,
      "follow count on non-header entry")

   `RDSAF_ASSERT(a_single_follow_not_last, clock, reset,
      !empty && rsp_data.kind == KIND_COUNT && rsp_data.follow_count == 5'd1 |-> !rsp_data.last,
      "single-follow header marked last")

   `RDSAF_ASSERT(a_stall_holds, clock, reset,
      !empty && !pop |=> !empty && $stable(rsp_data), "result changed while stalled")

endmodule

bind rds_af_code_pair_decoder rdsaf_checker u_checker (.*);

`default_nettype wire
